@@ rtl/dtcf_pkg.sv @@
`default_nettype none
package dtcf_pkg;

   // defaults of the top level parameters
   localparam int MAX_EXP_BITS_DEFAULT  = 11;
   localparam int MAX_FRAC_BITS_DEFAULT = 52;

   // binary64 layout
   localparam int DBL_WIDTH    = 64;
   localparam int DBL_EXP_BITS = 11;
   localparam int DBL_MAN_BITS = 52;
   localparam int SIG_BITS     = DBL_MAN_BITS + 1;
   localparam int DBL_BIAS     = 1023;

   // signed unbiased exponent, covers -1074 .. 2047
   localparam int EXP_S_BITS = 13;

   // configuration register widths and indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 6;
   localparam int EW_REG_BITS    = 4;
   localparam int FW_REG_BITS    = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INCLUDE_SIGN   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPONENT_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRACTION_WIDTH = 2'd2;

   localparam logic [EW_REG_BITS-1:0] EW_RESET = 4'd8;
   localparam logic [FW_REG_BITS-1:0] FW_RESET = 6'd23;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO     = 2'd1,
      STATUS_OVERFLOW = 2'd2,
      STATUS_SPECIAL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CLASS_NORMAL,
      CLASS_SUBNORMAL,
      CLASS_ZERO,
      CLASS_SPECIAL
   } class_type;

   // effective target format
   typedef struct packed {
      logic [EW_REG_BITS-1:0] exp_width;
      logic [FW_REG_BITS-1:0] frac_width;
   } fmt_type;

   // normalised operand handed to the rounding stage
   typedef struct packed {
      class_type              cls;
      logic                   sign;
      logic [SIG_BITS-1:0]    sig;
      logic [EXP_S_BITS-1:0]  exp;
   } norm_type;

endpackage
`default_nettype wire

@@ rtl/dtcf_round.sv @@
`default_nettype none
module dtcf_round #(
   parameter int MAX_EXP_BITS  = dtcf_pkg::MAX_EXP_BITS_DEFAULT,
   parameter int MAX_FRAC_BITS = dtcf_pkg::MAX_FRAC_BITS_DEFAULT
) (
   input  wire  dtcf_pkg::norm_type       norm,
   input  wire  dtcf_pkg::fmt_type        fmt,
   output logic                           sign_out,
   output logic [MAX_EXP_BITS-1:0]        exponent_field,
   output logic [MAX_FRAC_BITS-1:0]       fraction_field,
   output dtcf_pkg::status_type           status
);

   localparam int SB = dtcf_pkg::SIG_BITS;
   localparam int XB = dtcf_pkg::EXP_S_BITS;

   logic [dtcf_pkg::FW_REG_BITS-1:0] drop;
   logic [SB-1:0]                    quot;
   logic [SB-1:0]                    rshift;
   logic                             rnd;
   logic [SB:0]                      sum;
   logic                             carry;
   logic [MAX_EXP_BITS-1:0]          exp_ones;
   logic [MAX_FRAC_BITS-1:0]         frac_ones;
   logic [XB-1:0]                    bias;
   logic signed [XB-1:0]             biased;

   always_comb begin
      drop   = dtcf_pkg::FW_REG_BITS'(dtcf_pkg::DBL_MAN_BITS) - fmt.frac_width;
      quot   = norm.sig >> drop;
      rshift = norm.sig >> (drop - 1'b1);
      rnd    = (drop != '0) && rshift[0];
      // round half away from zero on the magnitude
      sum    = {1'b0, quot} + (SB+1)'(rnd);
      carry  = sum[fmt.frac_width + 1'b1];

      exp_ones  = MAX_EXP_BITS'((1 << fmt.exp_width) - 1);
      frac_ones = MAX_FRAC_BITS'((64'd1 << fmt.frac_width) - 64'd1);
      bias      = XB'((1 << (fmt.exp_width - 1'b1)) - 1);
      biased    = $signed(norm.exp) + $signed(bias) + $signed({{(XB-1){1'b0}}, carry});

      sign_out       = norm.sign;
      exponent_field = '0;
      fraction_field = '0;
      status         = dtcf_pkg::STATUS_OK;
      case (norm.cls)
         dtcf_pkg::CLASS_SPECIAL: begin
            exponent_field = exp_ones;
            fraction_field = frac_ones;
            status         = dtcf_pkg::STATUS_SPECIAL;
         end
         dtcf_pkg::CLASS_ZERO: begin
            sign_out = 1'b0;
            status   = dtcf_pkg::STATUS_ZERO;
         end
         default: begin
            if (biased < 0) begin
               status = dtcf_pkg::STATUS_ZERO;
            end else if (biased > $signed({{(XB-MAX_EXP_BITS){1'b0}}, exp_ones})) begin
               exponent_field = exp_ones;
               fraction_field = frac_ones;
               status         = dtcf_pkg::STATUS_OVERFLOW;
            end else begin
               exponent_field = MAX_EXP_BITS'(biased) & exp_ones;
               fraction_field = sum[MAX_FRAC_BITS-1:0] & frac_ones;
            end
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/double_to_custom_float_converter.sv @@
`default_nettype none
// double to custom float converter
//
// takes an ieee binary64 bit pattern on req_value_bits and returns sign,
// biased exponent and rounded fraction in a format set by the csr registers
// (include_sign at index 0, exponent_width at 1, fraction_width at 2)
//
// a beat is taken at a rising edge with start high and busy low; busy is
// never raised, so one beat may be taken every cycle
// each result is shown for one cycle with rsp_valid high, once the beat has
// passed the input and result registers; the receiver cannot stall, results
// stream at the rate beats arrive, one per cycle
//
// datapath: input register, then classify, leading zero count, normalising
// shift, rounding and range check in one pass into the result register
//
// csr writes take effect at once and should be made only while no beat is
// in flight; reset is synchronous, clears all valid bits and loads the
// register defaults (sign on, 8 exponent bits, 23 fraction bits)
module double_to_custom_float_converter #(
   parameter int MAX_EXP_BITS  = dtcf_pkg::MAX_EXP_BITS_DEFAULT,
   parameter int MAX_FRAC_BITS = dtcf_pkg::MAX_FRAC_BITS_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    start,
   output logic                                   busy,
   input  wire  [dtcf_pkg::DBL_WIDTH-1:0]         req_value_bits,
   output logic                                   rsp_valid,
   output logic                                   rsp_sign_out,
   output logic [MAX_EXP_BITS-1:0]                rsp_exponent_field,
   output logic [MAX_FRAC_BITS-1:0]               rsp_fraction_field,
   output logic [1:0]                             rsp_status,
   input  wire                                    csr_write_enable,
   input  wire  [dtcf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [dtcf_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);

   localparam int MB = dtcf_pkg::DBL_MAN_BITS;
   localparam int SB = dtcf_pkg::SIG_BITS;
   localparam int XB = dtcf_pkg::EXP_S_BITS;

   // configuration
   logic                              incl_sign_ff;
   logic [dtcf_pkg::EW_REG_BITS-1:0]  exp_width_ff;
   logic [dtcf_pkg::FW_REG_BITS-1:0]  frac_width_ff;
   dtcf_pkg::fmt_type                 fmt;

   always_ff @(posedge clock) begin
      if (reset) begin
         incl_sign_ff  <= 1'b1;
         exp_width_ff  <= dtcf_pkg::EW_RESET;
         frac_width_ff <= dtcf_pkg::FW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            dtcf_pkg::CSR_INCLUDE_SIGN:   incl_sign_ff  <= csr_write_data[0];
            dtcf_pkg::CSR_EXPONENT_WIDTH: begin
               exp_width_ff <= csr_write_data[dtcf_pkg::EW_REG_BITS-1:0];
            end
            dtcf_pkg::CSR_FRACTION_WIDTH: frac_width_ff <= csr_write_data;
            default: ; // unknown index, write dropped
         endcase
      end
   end

   // widths saturate to the legal range
   always_comb begin
      fmt.exp_width = exp_width_ff;
      if (exp_width_ff < 4'd2) begin
         fmt.exp_width = 4'd2;
      end else if (exp_width_ff > dtcf_pkg::EW_REG_BITS'(MAX_EXP_BITS)) begin
         fmt.exp_width = dtcf_pkg::EW_REG_BITS'(MAX_EXP_BITS);
      end
      fmt.frac_width = frac_width_ff;
      if (frac_width_ff < 6'd1) begin
         fmt.frac_width = 6'd1;
      end else if (frac_width_ff > dtcf_pkg::FW_REG_BITS'(MAX_FRAC_BITS)) begin
         fmt.frac_width = dtcf_pkg::FW_REG_BITS'(MAX_FRAC_BITS);
      end
   end

   assign busy = 1'b0;
   logic accept;
   assign accept = start && !busy;

   // input register
   logic                          s1_valid_ff;
   logic [dtcf_pkg::DBL_WIDTH-1:0] s1_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_value_ff <= req_value_bits;
      end
   end

   // classify and count leading zeros of the fraction
   logic [dtcf_pkg::DBL_EXP_BITS-1:0] s1_bexp;
   logic [MB-1:0]                     s1_mant;
   logic [5:0]                        lz_in;
   dtcf_pkg::class_type               cls_in;

   always_comb begin
      s1_bexp = s1_value_ff[dtcf_pkg::DBL_WIDTH-2:MB];
      s1_mant = s1_value_ff[MB-1:0];
      lz_in   = '0;
      for (int i = 0; i < MB; i++) begin
         if (s1_mant[i]) begin
            lz_in = 6'(MB - 1 - i);
         end
      end
      if (s1_bexp == '1) begin
         cls_in = dtcf_pkg::CLASS_SPECIAL;
      end else if (s1_bexp != '0) begin
         cls_in = dtcf_pkg::CLASS_NORMAL;
      end else if (s1_mant == '0) begin
         cls_in = dtcf_pkg::CLASS_ZERO;
      end else begin
         cls_in = dtcf_pkg::CLASS_SUBNORMAL;
      end
   end

   // normalise, subnormals shift their leading one to the top
   dtcf_pkg::norm_type norm_in;

   always_comb begin
      norm_in.cls  = cls_in;
      norm_in.sign = s1_value_ff[dtcf_pkg::DBL_WIDTH-1] && incl_sign_ff;
      if (cls_in == dtcf_pkg::CLASS_SUBNORMAL) begin
         norm_in.sig = {1'b0, s1_mant} << (lz_in + 1'b1);
         norm_in.exp = XB'(-dtcf_pkg::DBL_BIAS) - XB'(lz_in);
      end else begin
         norm_in.sig = {1'b1, s1_mant};
         norm_in.exp = XB'(s1_bexp) - XB'(dtcf_pkg::DBL_BIAS);
      end
   end

   // round, range check, result register
   logic                      sign_in;
   logic [MAX_EXP_BITS-1:0]   exp_in;
   logic [MAX_FRAC_BITS-1:0]  frac_in;
   dtcf_pkg::status_type      status_in;

   dtcf_round #(
      .MAX_EXP_BITS  (MAX_EXP_BITS),
      .MAX_FRAC_BITS (MAX_FRAC_BITS)
   ) u_round (
      .norm           (norm_in),
      .fmt            (fmt),
      .sign_out       (sign_in),
      .exponent_field (exp_in),
      .fraction_field (frac_in),
      .status         (status_in)
   );

   logic                     rsp_valid_ff;
   logic                     rsp_sign_ff;
   logic [MAX_EXP_BITS-1:0]  rsp_exp_ff;
   logic [MAX_FRAC_BITS-1:0] rsp_frac_ff;
   logic [1:0]               rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
      rsp_sign_ff   <= sign_in;
      rsp_exp_ff    <= exp_in;
      rsp_frac_ff   <= frac_in;
      rsp_status_ff <= status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sign_out       = rsp_sign_ff;
   assign rsp_exponent_field = rsp_exp_ff;
   assign rsp_fraction_field = rsp_frac_ff;
   assign rsp_status         = rsp_status_ff;

   // every accepted beat comes out through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("result missing after accepted beat");

   // no result without an accepted beat that passed the input register
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("result without a beat");

   // zero or underflow carries cleared fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dtcf_pkg::STATUS_ZERO) |->
      (rsp_exponent_field == '0 && rsp_fraction_field == '0))
      else $error("underflow result has nonzero fields");

   // saturated results keep a nonzero fraction and a nonzero exponent
   a_sat_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == dtcf_pkg::STATUS_OVERFLOW ||
                     rsp_status == dtcf_pkg::STATUS_SPECIAL)) |->
      (rsp_fraction_field != '0 && rsp_exponent_field != '0))
      else $error("saturated result not all ones");

endmodule
`default_nettype wire

@@ tb/dtcf_checker.sv @@
`timescale 1ns / 100ps
module dtcf_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire         busy,
   input  wire  [63:0] req_value_bits,
   input  wire         rsp_valid,
   input  wire         rsp_sign_out,
   input  wire  [10:0] rsp_exponent_field,
   input  wire  [51:0] rsp_fraction_field,
   input  wire  [1:0]  rsp_status,
   input  wire         csr_write_enable,
   input  wire  [1:0]  csr_index,
   input  wire  [5:0]  csr_write_data,
   output int          fail_count,
   output int          pending,
   output int          seen_count
);

   typedef struct packed {
      logic                 sign;
      logic [10:0]          exp;
      logic [51:0]          frac;
      dtcf_pkg::status_type status;
   } minifloat_type;

   logic          sign_on;
   logic [3:0]    ew_reg;
   logic [5:0]    fw_reg;
   minifloat_type conversions_due[$];

   function automatic minifloat_type convert(logic [63:0] v);
      minifloat_type r;
      int ew, fw, e, bias, biased, p;
      logic [63:0] sig, exp_ones, frac_ones;
      logic neg;
      ew = (ew_reg < 2) ? 2 : (ew_reg > 11) ? 11 : ew_reg;
      fw = (fw_reg < 1) ? 1 : (fw_reg > 52) ? 52 : fw_reg;
      exp_ones = (64'd1 << ew) - 1;
      frac_ones = (64'd1 << fw) - 1;
      neg = v[63];
      r = '0;
      r.sign = sign_on & neg;
      if (v[62:52] == 11'h7ff) begin
         r.exp = exp_ones[10:0]; r.frac = frac_ones[51:0];
         r.status = dtcf_pkg::STATUS_SPECIAL;
         return r;
      end
      if (v[62:0] == 63'd0) begin
         r.sign = 1'b0; r.status = dtcf_pkg::STATUS_ZERO;
         return r;
      end
      if (v[62:52] == 0) begin
         p = 51;
         while (v[p] == 1'b0) p--;
         sig = {12'd0, v[51:0]} << (52 - p);
         e = p - 1074;
      end else begin
         sig = {11'd0, 1'b1, v[51:0]};
         e = int'(v[62:52]) - 1023;
      end
      if (fw < 52) sig = (sig + (64'd1 << (51 - fw))) >> (52 - fw);
      if ((sig >> (fw + 1)) != 0) begin
         sig = 64'd1 << fw;
         e++;
      end
      bias = (1 << (ew - 1)) - 1;
      biased = e + bias;
      if (biased < 0) r.status = dtcf_pkg::STATUS_ZERO;
      else if (biased > int'(exp_ones)) begin
         r.exp = exp_ones[10:0]; r.frac = frac_ones[51:0];
         r.status = dtcf_pkg::STATUS_OVERFLOW;
      end else begin
         r.exp = biased[10:0]; r.frac = sig[51:0] & frac_ones[51:0];
         r.status = dtcf_pkg::STATUS_OK;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      minifloat_type want;
      if (reset) begin
         sign_on <= 1'b1; ew_reg <= dtcf_pkg::EW_RESET; fw_reg <= dtcf_pkg::FW_RESET;
         conversions_due.delete();
         fail_count <= 0; seen_count <= 0;
      end else begin
         if (rsp_valid) begin
            seen_count <= seen_count + 1;
            if (conversions_due.size() == 0) begin
               $error("unexpected result beat");
               fail_count <= fail_count + 1;
            end else begin
               want = conversions_due.pop_front();
               if (rsp_sign_out !== want.sign || rsp_exponent_field !== want.exp ||
                   rsp_fraction_field !== want.frac || rsp_status !== want.status)
                  fail_count <= fail_count + 1;
               if (rsp_sign_out !== want.sign)
                  $error("sign_out expected %0d actual %0d", want.sign, rsp_sign_out);
               if (rsp_exponent_field !== want.exp)
                  $error("exponent_field expected %h actual %h", want.exp,
                         rsp_exponent_field);
               if (rsp_fraction_field !== want.frac)
                  $error("fraction_field expected %h actual %h", want.frac,
                         rsp_fraction_field);
               if (rsp_status !== want.status)
                  $error("status expected %0d actual %0d", want.status, rsp_status);
            end
         end
         if (start && !busy) conversions_due.push_back(convert(req_value_bits));
         if (csr_write_enable) begin
            case (csr_index)
               dtcf_pkg::CSR_INCLUDE_SIGN:   sign_on <= csr_write_data[0];
               dtcf_pkg::CSR_EXPONENT_WIDTH: ew_reg <= csr_write_data[3:0];
               dtcf_pkg::CSR_FRACTION_WIDTH: fw_reg <= csr_write_data[5:0];
               default: ;
            endcase
         end
      end
   end

   assign pending = conversions_due.size();
endmodule

@@ tb/tb_double_to_custom_float_converter.sv @@
`timescale 1ns / 100ps
module tb_double_to_custom_float_converter;

   // index with no register behind it
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock, reset, start, busy;
   logic [63:0] req_value_bits;
   logic        rsp_valid, rsp_sign_out;
   logic [10:0] rsp_exponent_field;
   logic [51:0] rsp_fraction_field;
   logic [1:0]  rsp_status;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [5:0]  csr_write_data;
   int          fail_count, pending, seen_count, beats_sent;
   int          cycle_count = 0;

   double_to_custom_float_converter dut (.*);

   dtcf_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog, ends a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // random double with bias towards interesting exponents
   function automatic logic [63:0] random_double();
      logic [63:0] v;
      int sel;
      v = {$urandom, $urandom};
      sel = $urandom_range(0, 9);
      case (sel)
         0: v[62:52] = 11'd0;                              // subnormal or zero
         1: v[62:52] = 11'h7ff;                            // nan or infinity
         2: v[62:52] = 11'(1023 + $urandom_range(0, 20) - 10);
         3: v[62:52] = 11'(1023 + $urandom_range(0, 2100) - 1050);
         4: v[51:0]  = {4'($urandom_range(0, 15)), 48'hffff_ffff_ffff}; // rounding carry
         default: ;
      endcase
      if (sel == 0 && $urandom_range(0, 3) == 0) v[51:0] = 52'd1 << $urandom_range(0, 51);
      return v;
   endfunction

   // one beat, launched on the falling edge, held until accepted
   task automatic send_beat(input logic [63:0] v);
      @(negedge clock);
      start <= 1'b1;
      req_value_bits <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
   endtask

   task automatic drop_start();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // csr write only once the pipe has drained
   task automatic write_csr(input logic [1:0] idx, input logic [5:0] data);
      drop_start();
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_format(input logic s, input logic [3:0] ew, input logic [5:0] fw);
      write_csr(dtcf_pkg::CSR_INCLUDE_SIGN, {5'd0, s});
      write_csr(dtcf_pkg::CSR_EXPONENT_WIDTH, {2'd0, ew});
      write_csr(dtcf_pkg::CSR_FRACTION_WIDTH, fw);
   endtask

   // random burst of beats with gaps of varied length
   task automatic send_bursts(input int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && count > 0; i++) begin
            send_beat(random_double());
            count--;
         end
         if ($urandom_range(0, 2) != 0) begin
            drop_start();
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
      end
   endtask

   logic [63:0] directed[$] = '{
      64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,   // zeros
      64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0000,   // +/- one
      64'h3fff_ffff_ffff_ffff, 64'h7fef_ffff_ffff_ffff,   // round carry, largest
      64'h0000_0000_0000_0001, 64'h000f_ffff_ffff_ffff,   // subnormals
      64'h0010_0000_0000_0000, 64'h7ff0_0000_0000_0000,   // min normal, +inf
      64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0001,   // -inf, nan
      64'hfff7_ffff_ffff_ffff, 64'h3ff8_0000_0000_0000,   // negative nan, 1.5
      64'h4700_0000_0000_0000, 64'h3800_0000_0000_0000,   // near float limits
      64'hc7ef_ffff_f000_0000, 64'h3690_0000_0000_0000,
      64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa
   };

   initial begin
      reset = 1'b1; start = 1'b0; req_value_bits = '0;
      csr_write_enable = 1'b0; csr_index = '0; csr_write_data = '0;
      beats_sent = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats at the reset format, then at the extremes
      foreach (directed[i]) send_beat(directed[i]);
      set_format(1'b0, 4'd2, 6'd1);
      foreach (directed[i]) send_beat(directed[i]);
      set_format(1'b1, 4'd11, 6'd52);
      foreach (directed[i]) send_beat(directed[i]);
      set_format(1'b1, 4'd0, 6'd63);   // out of range widths saturate
      foreach (directed[i]) send_beat(directed[i]);

      // random phases, each at a new format
      for (int ph = 0; ph < 12; ph++) begin
         set_format(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                    6'($urandom_range(0, 63)));
         if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED, 6'($urandom_range(0, 63)));
         send_bursts(150);
      end
      drop_start();

      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("converted %0d values over 16 formats, %0d results checked",
               beats_sent, seen_count);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
